// ----- rtl/chip8_cpu_core_unit_defines.svh -----
// ----------------------------------------------------------------------------
// chip8 cpu core assertion macros
// shared check helpers for the core rtl
// ----------------------------------------------------------------------------
`ifndef CHIP8_CPU_CORE_UNIT_DEFINES_SVH
`define CHIP8_CPU_CORE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define C8_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define C8_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/c8core_pkg.sv -----
// ----------------------------------------------------------------------------
// c8core_pkg
// types, constants and small tables shared by the chip8 core modules
// ----------------------------------------------------------------------------
`default_nettype none

package c8core_pkg;

    localparam int unsigned MEM_BYTES  = 4096;
    localparam int unsigned ADDR_W     = 12;
    localparam int unsigned SCREEN_W   = 64;
    localparam int unsigned SCREEN_H   = 32;
    localparam int unsigned ROW_W      = 5;
    localparam int unsigned FONT_BYTES = 80;
    localparam int unsigned NUM_VREGS  = 16;

    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_EXEC     = 2'd1;
    localparam logic [1:0] OP_READ_ROW = 2'd2;

    localparam logic [2:0] ALU_ADD  = 3'd0;
    localparam logic [2:0] ALU_SUB  = 3'd1;
    localparam logic [2:0] ALU_AND  = 3'd2;
    localparam logic [2:0] ALU_OR   = 3'd3;
    localparam logic [2:0] ALU_XOR  = 3'd4;
    localparam logic [2:0] ALU_SHR  = 3'd5;
    localparam logic [2:0] ALU_SHL  = 3'd6;
    localparam logic [2:0] ALU_PASS = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] mem_address;
        logic [7:0]  mem_data;
        logic [15:0] key_state;
        logic [7:0]  random_byte;
        logic [4:0]  row_select;
    } t_in_word;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] executed_opcode;
        logic        illegal_opcode;
        logic        screen_changed;
        logic        sound_active;
        logic [63:0] row_pixels;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] a;
        logic [11:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [11:0] res;
        logic        flag;
        logic        eq;
    } t_alu_rsp;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // decimal digit k of v: 0 hundreds, 1 tens, 2 ones
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] k);
        logic [1:0] hund;
        logic [7:0] rem;
        logic [3:0] tens;
        logic [7:0] ones;
        hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem  = v - 8'(hund * 8'd100);
        tens = 4'd0;
        for (int j = 1; j < 10; j++) begin
            if (rem >= 8'(j * 10)) begin
                tens = 4'(j);
            end
        end
        ones = rem - 8'(tens * 8'd10);
        unique case (k)
            2'd0: bcd_digit = {6'd0, hund};
            2'd1: bcd_digit = {4'd0, tens};
            2'd2: bcd_digit = ones;
            default: bcd_digit = 8'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- rtl/c8core_alu.sv -----
// ----------------------------------------------------------------------------
// c8core_alu
// shared arithmetic unit: 8-bit data ops with flag, 12-bit address adds
// ----------------------------------------------------------------------------
`default_nettype none

module c8core_alu (
    input  c8core_pkg::t_alu_req i_req,
    output c8core_pkg::t_alu_rsp o_rsp
);
    import c8core_pkg::*;

    logic [12:0] sum;
    logic [12:0] diff;

    assign sum  = {1'b0, i_req.a} + {1'b0, i_req.b};
    assign diff = {1'b0, i_req.a} - {1'b0, i_req.b};

    always_comb begin
        o_rsp.eq = (i_req.a == i_req.b);
        unique case (i_req.op)
            ALU_ADD: begin
                o_rsp.res  = sum[11:0];
                o_rsp.flag = sum[8];
            end
            ALU_SUB: begin
                o_rsp.res  = diff[11:0];
                o_rsp.flag = ~diff[12];
            end
            ALU_AND: begin
                o_rsp.res  = i_req.a & i_req.b;
                o_rsp.flag = 1'b0;
            end
            ALU_OR: begin
                o_rsp.res  = i_req.a | i_req.b;
                o_rsp.flag = 1'b0;
            end
            ALU_XOR: begin
                o_rsp.res  = i_req.a ^ i_req.b;
                o_rsp.flag = 1'b0;
            end
            ALU_SHR: begin
                o_rsp.res  = {1'b0, i_req.a[11:1]};
                o_rsp.flag = i_req.a[0];
            end
            ALU_SHL: begin
                o_rsp.res  = {i_req.a[10:0], 1'b0};
                o_rsp.flag = i_req.a[7];
            end
            ALU_PASS: begin
                o_rsp.res  = i_req.b;
                o_rsp.flag = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/chip8_cpu_core_unit.sv -----
// ----------------------------------------------------------------------------
// chip8_cpu_core_unit
// chip8 processor core with program memory, register file and framebuffer
// ----------------------------------------------------------------------------
// After reset the core copies the hex font into memory and holds o_in_stall
// high meanwhile. One word is handled at a time by a small sequencer around
// one shared alu. A memory write, no-op or framebuffer row read goes straight
// to the output state. An execute word steps through two memory reads to fetch
// the opcode, two register-file reads, an execute state, a flag write where
// needed and the timer tick. Sprite draws add a memory and framebuffer read,
// then an xor write back, per sprite row; FX55 adds a store per register, FX65
// a read and a write per register and FX33 three digit writes, all set by the
// single memory port and single register-file port.
`default_nettype none

`include "chip8_cpu_core_unit_defines.svh"

module chip8_cpu_core_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  c8core_pkg::t_in_word    i_in_data,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output c8core_pkg::t_out_word   o_out_data,
    input  wire                     i_cfg_we,
    input  wire [11:0]              i_cfg_wdata
);
    import c8core_pkg::*;

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_FETCH_HI = 4'd2;
    localparam logic [3:0] S_FETCH_LO = 4'd3;
    localparam logic [3:0] S_RDX      = 4'd4;
    localparam logic [3:0] S_RDY      = 4'd5;
    localparam logic [3:0] S_EXEC     = 4'd6;
    localparam logic [3:0] S_WRF      = 4'd7;
    localparam logic [3:0] S_DRAW_RD  = 4'd8;
    localparam logic [3:0] S_DRAW_WR  = 4'd9;
    localparam logic [3:0] S_STORE    = 4'd10;
    localparam logic [3:0] S_LOAD_RD  = 4'd11;
    localparam logic [3:0] S_LOAD_WR  = 4'd12;
    localparam logic [3:0] S_BCD      = 4'd13;
    localparam logic [3:0] S_TICK     = 4'd14;
    localparam logic [3:0] S_OUT      = 4'd15;

    logic [3:0]  r_state;
    logic [6:0]  r_init_cnt;
    logic [11:0] r_pc;
    logic [11:0] r_i;
    logic [SP_W-1:0] r_sp;
    logic [7:0]  r_delay;
    logic [7:0]  r_sound;
    logic [7:0]  r_v [NUM_VREGS];
    logic [11:0] r_stack [STACK_DEPTH];
    logic [SCREEN_H-1:0] r_fb_valid;
    logic [7:0]  r_mem [MEM_BYTES];
    logic [7:0]  r_mem_q;
    logic [63:0] r_fb [SCREEN_H];
    logic [63:0] r_fb_q;
    logic        r_fb_qv;
    logic [7:0]  r_hi;
    logic [15:0] r_opc;
    logic [7:0]  r_vx;
    logic [7:0]  r_vy;
    logic [15:0] r_keys;
    logic [7:0]  r_rnd;
    logic [4:0]  r_row_sel;
    logic [1:0]  r_op;
    logic [3:0]  r_cnt;
    logic        r_hit;
    logic        r_flag;
    logic        r_illegal;
    logic        r_drew;
    logic        r_out_valid;
    t_out_word   r_out;

    logic        in_accept;
    logic        out_free;
    logic        m_we;
    logic [11:0] m_waddr;
    logic [7:0]  m_wdata;
    logic [11:0] m_raddr;
    logic        fb_we;
    logic [4:0]  fb_addr;
    logic [63:0] fb_wdata;
    logic [3:0]  v_raddr;
    logic [7:0]  v_rdata;
    t_alu_req    alu_req;
    t_alu_rsp    alu_rsp;
    logic [11:0] pc_next;
    logic [11:0] pc_skip;
    logic [4:0]  draw_y;
    logic [63:0] row_now;
    logic [63:0] sprite_pat;
    logic [127:0] sprite_dbl;
    logic        key_hit;
    logic [SP_W-1:0] sp_dec;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pc_next = r_pc + 12'd2;
    assign pc_skip = r_pc + 12'd4;
    assign draw_y  = r_vy[4:0] + {1'b0, r_cnt};
    assign row_now = r_fb_qv ? r_fb_q : 64'd0;
    // rotate the sprite byte right by x so it wraps around the row
    assign sprite_dbl = {r_mem_q, 56'd0, r_mem_q, 56'd0} >> r_vx[5:0];
    assign sprite_pat = sprite_dbl[63:0];
    assign key_hit = (r_vx[7:4] == 4'd0) && r_keys[r_vx[3:0]];
    assign sp_dec  = r_sp - SP_W'(1);
    assign v_rdata = r_v[v_raddr];

    c8core_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // alu operand select
    always_comb begin
        alu_req.op = ALU_ADD;
        alu_req.a  = r_i;
        alu_req.b  = {8'd0, r_cnt};
        if (r_state == S_EXEC) begin
            unique case (r_opc[15:12])
                4'h3, 4'h4: begin
                    alu_req.op = ALU_SUB;
                    alu_req.a  = {4'd0, r_vx};
                    alu_req.b  = {4'd0, r_opc[7:0]};
                end
                4'h7: begin
                    alu_req.a = {4'd0, r_vx};
                    alu_req.b = {4'd0, r_opc[7:0]};
                end
                4'h8: begin
                    alu_req.a = {4'd0, r_vx};
                    alu_req.b = {4'd0, r_vy};
                    unique case (r_opc[3:0])
                        4'h0: alu_req.op = ALU_PASS;
                        4'h1: alu_req.op = ALU_OR;
                        4'h2: alu_req.op = ALU_AND;
                        4'h3: alu_req.op = ALU_XOR;
                        4'h5: alu_req.op = ALU_SUB;
                        4'h6: alu_req.op = ALU_SHR;
                        4'h7: begin
                            alu_req.op = ALU_SUB;
                            alu_req.a  = {4'd0, r_vy};
                            alu_req.b  = {4'd0, r_vx};
                        end
                        4'hE: alu_req.op = ALU_SHL;
                        default: alu_req.op = ALU_ADD;
                    endcase
                end
                4'hB: begin
                    alu_req.a = {4'd0, r_vy};
                    alu_req.b = r_opc[11:0];
                end
                4'hF: begin
                    if (r_opc[7:0] == 8'h29) begin
                        alu_req.a = {2'd0, r_vx, 2'd0};
                    end else begin
                        alu_req.a = r_i;
                    end
                    alu_req.b = {4'd0, r_vx};
                end
                default: begin
                    alu_req.op = ALU_SUB;
                    alu_req.a  = {4'd0, r_vx};
                    alu_req.b  = {4'd0, r_vy};
                end
            endcase
        end
    end

    // memory, framebuffer and register-file ports
    always_comb begin
        m_we     = 1'b0;
        m_waddr  = alu_rsp.res;
        m_wdata  = v_rdata;
        m_raddr  = r_pc;
        fb_we    = 1'b0;
        fb_addr  = r_row_sel;
        fb_wdata = row_now ^ sprite_pat;
        v_raddr  = r_cnt;
        unique case (r_state)
            S_INIT: begin
                m_we    = 1'b1;
                m_waddr = {5'd0, r_init_cnt};
                m_wdata = FONT_ROM[r_init_cnt];
            end
            S_IDLE: begin
                m_we    = in_accept && (i_in_data.op == OP_WRITE);
                m_waddr = i_in_data.mem_address;
                m_wdata = i_in_data.mem_data;
                fb_addr = i_in_data.row_select;
            end
            S_FETCH_HI: m_raddr = pc_next - 12'd1;
            S_RDX:      v_raddr = r_opc[11:8];
            S_RDY:      v_raddr = (r_opc[15:12] == 4'hB) ? 4'd0 : r_opc[7:4];
            S_DRAW_RD: begin
                m_raddr = alu_rsp.res;
                fb_addr = draw_y;
            end
            S_DRAW_WR: begin
                fb_we   = 1'b1;
                fb_addr = draw_y;
            end
            S_STORE:   m_we = 1'b1;
            S_LOAD_RD: m_raddr = alu_rsp.res;
            S_BCD: begin
                m_we    = 1'b1;
                m_wdata = bcd_digit(r_vx, r_cnt[1:0]);
            end
            S_FETCH_LO, S_EXEC, S_WRF, S_LOAD_WR, S_TICK, S_OUT: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mem[m_waddr] <= m_wdata;
        end
        r_mem_q <= r_mem[m_raddr];
        if (fb_we) begin
            r_fb[fb_addr] <= fb_wdata;
        end
        r_fb_q <= r_fb[fb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_cnt  <= 7'd0;
            r_pc        <= 12'd512;
            r_i         <= 12'd0;
            r_sp        <= '0;
            r_delay     <= 8'd0;
            r_sound     <= 8'd0;
            r_fb_valid  <= '0;
            r_fb_qv     <= 1'b0;
            r_out_valid <= 1'b0;
            r_illegal   <= 1'b0;
            r_drew      <= 1'b0;
            r_op        <= OP_WRITE;
            r_cnt       <= 4'd0;
            r_hit       <= 1'b0;
            r_flag      <= 1'b0;
            for (int k = 0; k < NUM_VREGS; k++) begin
                r_v[k] <= 8'd0;
            end
        end else begin
            r_fb_qv <= r_fb_valid[fb_addr];
            if (fb_we) begin
                r_fb_valid[fb_addr] <= 1'b1;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_init_cnt <= r_init_cnt + 7'd1;
                    if (r_init_cnt == 7'(FONT_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_op      <= i_in_data.op;
                        r_keys    <= i_in_data.key_state;
                        r_rnd     <= i_in_data.random_byte;
                        r_row_sel <= i_in_data.row_select;
                        r_illegal <= 1'b0;
                        r_drew    <= 1'b0;
                        r_state   <= (i_in_data.op == OP_EXEC) ? S_FETCH_HI : S_OUT;
                    end
                end
                S_FETCH_HI: begin
                    r_hi    <= r_mem_q;
                    r_state <= S_FETCH_LO;
                end
                S_FETCH_LO: begin
                    r_opc   <= {r_hi, r_mem_q};
                    r_state <= S_RDX;
                end
                S_RDX: begin
                    r_vx    <= v_rdata;
                    r_state <= S_RDY;
                end
                S_RDY: begin
                    r_vy    <= v_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_cnt   <= 4'd0;
                    r_hit   <= 1'b0;
                    r_state <= S_TICK;
                    unique case (r_opc[15:12])
                        4'h0: begin
                            if (r_opc == 16'h00E0) begin
                                r_fb_valid <= '0;
                                r_drew     <= 1'b1;
                                r_pc       <= pc_next;
                            end else if (r_opc == 16'h00EE) begin
                                if (r_sp != '0) begin
                                    r_sp <= sp_dec;
                                    r_pc <= r_stack[sp_dec[IDX_W-1:0]];
                                end else begin
                                    r_pc <= pc_next;
                                end
                            end else begin
                                r_illegal <= 1'b1;
                            end
                        end
                        4'h1: r_pc <= r_opc[11:0];
                        4'h2: begin
                            // a full stack drops the return address
                            if (r_sp < SP_W'(STACK_DEPTH)) begin
                                r_stack[r_sp[IDX_W-1:0]] <= pc_next;
                                r_sp <= r_sp + SP_W'(1);
                            end
                            r_pc <= r_opc[11:0];
                        end
                        4'h3, 4'h5: r_pc <= alu_rsp.eq ? pc_skip : pc_next;
                        4'h4, 4'h9: r_pc <= alu_rsp.eq ? pc_next : pc_skip;
                        4'h6: begin
                            r_v[r_opc[11:8]] <= r_opc[7:0];
                            r_pc <= pc_next;
                        end
                        4'h7: begin
                            r_v[r_opc[11:8]] <= alu_rsp.res[7:0];
                            r_pc <= pc_next;
                        end
                        4'h8: begin
                            unique case (r_opc[3:0])
                                4'h0, 4'h1, 4'h2, 4'h3: begin
                                    r_v[r_opc[11:8]] <= alu_rsp.res[7:0];
                                    r_pc <= pc_next;
                                end
                                4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                                    r_v[r_opc[11:8]] <= alu_rsp.res[7:0];
                                    r_flag  <= alu_rsp.flag;
                                    r_pc    <= pc_next;
                                    r_state <= S_WRF;
                                end
                                default: r_illegal <= 1'b1;
                            endcase
                        end
                        4'hA: begin
                            r_i  <= r_opc[11:0];
                            r_pc <= pc_next;
                        end
                        4'hB: r_pc <= alu_rsp.res;
                        4'hC: begin
                            r_v[r_opc[11:8]] <= r_rnd & r_opc[7:0];
                            r_pc <= pc_next;
                        end
                        4'hD: begin
                            r_drew <= 1'b1;
                            r_pc   <= pc_next;
                            if (r_opc[3:0] == 4'd0) begin
                                r_flag  <= 1'b0;
                                r_state <= S_WRF;
                            end else begin
                                r_state <= S_DRAW_RD;
                            end
                        end
                        4'hE: begin
                            if (r_opc[7:0] == 8'h9E) begin
                                r_pc <= key_hit ? pc_skip : pc_next;
                            end else if (r_opc[7:0] == 8'hA1) begin
                                r_pc <= key_hit ? pc_next : pc_skip;
                            end else begin
                                r_illegal <= 1'b1;
                            end
                        end
                        4'hF: begin
                            r_pc <= pc_next;
                            unique case (r_opc[7:0])
                                8'h07: r_v[r_opc[11:8]] <= r_delay;
                                8'h0A: begin
                                end
                                8'h15: r_delay <= r_vx;
                                8'h18: r_sound <= r_vx;
                                8'h1E, 8'h29: r_i <= alu_rsp.res;
                                8'h33: r_state <= S_BCD;
                                8'h55: r_state <= S_STORE;
                                8'h65: r_state <= S_LOAD_RD;
                                default: begin
                                    r_illegal <= 1'b1;
                                    r_pc      <= r_pc;
                                end
                            endcase
                        end
                    endcase
                end
                S_WRF: begin
                    r_v[4'hF] <= r_flag;
                    r_state   <= S_TICK;
                end
                S_DRAW_RD: r_state <= S_DRAW_WR;
                S_DRAW_WR: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == r_opc[3:0] - 4'd1) begin
                        r_flag  <= r_hit | (|(row_now & sprite_pat));
                        r_state <= S_WRF;
                    end else begin
                        r_hit   <= r_hit | (|(row_now & sprite_pat));
                        r_state <= S_DRAW_RD;
                    end
                end
                S_STORE: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == r_opc[11:8]) begin
                        r_state <= S_TICK;
                    end
                end
                S_LOAD_RD: r_state <= S_LOAD_WR;
                S_LOAD_WR: begin
                    r_v[r_cnt] <= r_mem_q;
                    r_cnt <= r_cnt + 4'd1;
                    r_state <= (r_cnt == r_opc[11:8]) ? S_TICK : S_LOAD_RD;
                end
                S_BCD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd2) begin
                        r_state <= S_TICK;
                    end
                end
                S_TICK: begin
                    if (r_delay != 8'd0) begin
                        r_delay <= r_delay - 8'd1;
                    end
                    if (r_sound != 8'd0) begin
                        r_sound <= r_sound - 8'd1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out.program_counter <= r_pc;
                        r_out.executed_opcode <= (r_op == OP_EXEC) ? r_opc : 16'd0;
                        r_out.illegal_opcode  <= r_illegal;
                        r_out.screen_changed  <= r_drew;
                        r_out.sound_active    <= (r_sound != 8'd0);
                        r_out.row_pixels      <= (r_op == OP_READ_ROW) ? row_now : 64'd0;
                        r_state               <= S_IDLE;
                    end
                end
            endcase

            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
        end
    end

    `C8_ASSERT_IMP(a_sp_range, 1'b1, r_sp <= SP_W'(STACK_DEPTH), "stack pointer past depth")
    `C8_ASSERT_NXT(a_exec_fetch, in_accept && (i_in_data.op == OP_EXEC), r_state == S_FETCH_HI, "execute word did not start fetch")
    `C8_ASSERT_IMP(a_out_src, $rose(r_out_valid), $past(r_state) == S_OUT, "result word loaded outside output state")

endmodule

`default_nettype wire

// ----- sim/chip8_cpu_core_unit_tb.sv -----
// ----------------------------------------------------------------------------
// chip8_cpu_core_unit_tb
// drives memory writes, no-ops, instruction executes and framebuffer row reads into
// the core; a scoreboard runs its own copy of the machine state and checks
// every result word in order, mostly under random gaps and receiver stalls
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_cpu_core_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c8core_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int STACK_SLOTS = 16;

    class c8_scoreboard;
        bit [7:0]  mem [MEM_BYTES];
        bit        known [MEM_BYTES];
        bit [7:0]  vreg [16];
        bit [11:0] idx;
        bit [11:0] pc;
        bit [11:0] stk [STACK_SLOTS];
        int        sp;
        bit [7:0]  delay_t;
        bit [7:0]  sound_t;
        bit [63:0] fb [32];
        t_out_word pending [$];
        int        fails;

        function new();
            for (int a = 0; a < MEM_BYTES; a++) begin
                mem[a] = (a < FONT_BYTES) ? FONT_ROM[a] : 8'd0;
                known[a] = (a < FONT_BYTES);
            end
            for (int k = 0; k < 16; k++) vreg[k] = 0;
            for (int r = 0; r < 32; r++) fb[r] = 0;
            idx = 0; pc = 12'd512; sp = 0; delay_t = 0; sound_t = 0; fails = 0;
        endfunction

        function void set_start(bit [11:0] a);
            pc = a;
        endfunction

        function void put_mem(bit [11:0] a, bit [7:0] d);
            mem[a] = d;
            known[a] = 1;
        endfunction

        function bit key_hit(bit [15:0] keys, bit [7:0] k);
            if (k > 15) return 0;
            return keys[k[3:0]];
        endfunction

        // returns 1 when the opcode is recognised
        function bit run_opcode(bit [15:0] opc, bit [15:0] keys, bit [7:0] rnd,
                                output bit drew);
            bit [3:0]  x;
            bit [3:0]  y;
            bit [7:0]  nn;
            bit [11:0] nnn;
            bit [3:0]  n;
            bit [7:0]  vx;
            bit [7:0]  vy;
            bit [11:0] nxt;
            bit [11:0] skp;
            bit [8:0]  sum;
            bit [7:0]  res;
            bit        flag;
            bit        hit;
            bit [7:0]  line;
            bit [11:0] a;
            int        px;
            int        py;
            x = opc[11:8]; y = opc[7:4]; nn = opc[7:0]; nnn = opc[11:0]; n = opc[3:0];
            vx = vreg[x]; vy = vreg[y];
            nxt = pc + 12'd2; skp = pc + 12'd4;
            drew = 0;
            case (opc[15:12])
                4'h0: begin
                    if (opc == 16'h00E0) begin
                        for (int r = 0; r < 32; r++) fb[r] = 0;
                        drew = 1;
                        pc = nxt;
                    end else if (opc == 16'h00EE) begin
                        if (sp > 0) begin
                            sp--;
                            pc = stk[sp];
                        end else begin
                            pc = nxt;
                        end
                    end else begin
                        return 0;
                    end
                end
                4'h1: pc = nnn;
                4'h2: begin
                    // full stack drops the return address
                    if (sp < STACK_SLOTS) begin
                        stk[sp] = nxt;
                        sp++;
                    end
                    pc = nnn;
                end
                4'h3: pc = (vx == nn) ? skp : nxt;
                4'h4: pc = (vx != nn) ? skp : nxt;
                4'h5: pc = (vx == vy) ? skp : nxt;
                4'h6: begin vreg[x] = nn; pc = nxt; end
                4'h7: begin vreg[x] = vx + nn; pc = nxt; end
                4'h8: begin
                    flag = 0;
                    case (n)
                        4'h0: res = vy;
                        4'h1: res = vx | vy;
                        4'h2: res = vx & vy;
                        4'h3: res = vx ^ vy;
                        4'h4: begin sum = vx + vy; res = sum[7:0]; flag = sum[8]; end
                        4'h5: begin res = vx - vy; flag = (vx >= vy); end
                        4'h6: begin res = vx >> 1; flag = vx[0]; end
                        4'h7: begin res = vy - vx; flag = (vy >= vx); end
                        4'hE: begin res = vx << 1; flag = vx[7]; end
                        default: return 0;
                    endcase
                    vreg[x] = res;
                    // flag goes in after the result
                    if (n >= 4) vreg[15] = {7'd0, flag};
                    pc = nxt;
                end
                4'h9: pc = (vx != vy) ? skp : nxt;
                4'hA: begin idx = nnn; pc = nxt; end
                4'hB: pc = {4'd0, vreg[0]} + nnn;
                4'hC: begin vreg[x] = rnd & nn; pc = nxt; end
                4'hD: begin
                    hit = 0;
                    for (int r = 0; r < n; r++) begin
                        a = idx + 12'(r);
                        line = mem[a];
                        py = (vy + r) % 32;
                        for (int c = 0; c < 8; c++) begin
                            if (line[7-c]) begin
                                px = (vx + c) % 64;
                                if (fb[py][63-px]) hit = 1;
                                fb[py][63-px] = ~fb[py][63-px];
                            end
                        end
                    end
                    vreg[15] = {7'd0, hit};
                    drew = 1;
                    pc = nxt;
                end
                4'hE: begin
                    if (nn == 8'h9E) pc = key_hit(keys, vx) ? skp : nxt;
                    else if (nn == 8'hA1) pc = key_hit(keys, vx) ? nxt : skp;
                    else return 0;
                end
                default: begin
                    case (nn)
                        8'h07: vreg[x] = delay_t;
                        8'h0A: ;
                        8'h15: delay_t = vx;
                        8'h18: sound_t = vx;
                        8'h1E: idx = idx + {4'd0, vx};
                        8'h29: idx = 12'(vx * 5);
                        8'h33: begin
                            put_mem(idx, vx / 100);
                            put_mem(idx + 12'd1, (vx / 10) % 10);
                            put_mem(idx + 12'd2, vx % 10);
                        end
                        8'h55: for (int i = 0; i <= x; i++) put_mem(idx + 12'(i), vreg[i]);
                        8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem[idx + 12'(i)];
                        default: return 0;
                    endcase
                    pc = nxt;
                end
            endcase
            return 1;
        endfunction

        function void note_input(t_in_word w);
            t_out_word e;
            bit [15:0] opc;
            bit        drew;
            e = '0;
            if (w.op == OP_WRITE) begin
                put_mem(w.mem_address, w.mem_data);
            end else if (w.op == OP_EXEC) begin
                opc = {mem[pc], mem[pc + 12'd1]};
                e.executed_opcode = opc;
                e.illegal_opcode = ~run_opcode(opc, w.key_state, w.random_byte, drew);
                e.screen_changed = drew;
                if (delay_t != 0) delay_t--;
                if (sound_t != 0) sound_t--;
            end else if (w.op == OP_READ_ROW) begin
                e.row_pixels = fb[w.row_select];
            end
            e.program_counter = pc;
            e.sound_active = (sound_t != 0);
            pending.push_back(e);
        endfunction

        function void check_result(t_out_word got);
            t_out_word e;
            bit bad;
            if (pending.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result word pc=%h", got.program_counter);
                return;
            end
            e = pending.pop_front();
            bad = (got.program_counter !== e.program_counter) ||
                  (got.executed_opcode !== e.executed_opcode) ||
                  (got.illegal_opcode !== e.illegal_opcode) ||
                  (got.screen_changed !== e.screen_changed) ||
                  (got.sound_active !== e.sound_active) ||
                  (got.row_pixels !== e.row_pixels);
            if (bad) begin
                fails++;
                if (fails <= 10) begin
                    $display("mismatch exp pc=%h opc=%h ill=%b scr=%b snd=%b row=%h",
                             e.program_counter, e.executed_opcode, e.illegal_opcode,
                             e.screen_changed, e.sound_active, e.row_pixels);
                    $display("         got pc=%h opc=%h ill=%b scr=%b snd=%b row=%h",
                             got.program_counter, got.executed_opcode, got.illegal_opcode,
                             got.screen_changed, got.sound_active, got.row_pixels);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_data;
    logic        i_cfg_we;
    logic [11:0] i_cfg_wdata;

    c8_scoreboard sb;
    bit tx_quiet;
    bit rx_quiet;

    chip8_cpu_core_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_in_word rand_word(logic [1:0] op);
        t_in_word w;
        w = t_in_word'({$urandom, $urandom});
        w.op = op;
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        int g;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
        g = tx_quiet ? 0 : gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic write_byte(bit [11:0] a, bit [7:0] d);
        t_in_word w;
        w = rand_word(OP_WRITE);
        w.mem_address = a;
        w.mem_data = d;
        send_word(w);
    endtask

    task automatic fill_byte(bit [11:0] a);
        if (!sb.known[a]) write_byte(a, 8'($urandom));
    endtask

    // fills any bytes it reads, then loads the opcode at pc (mostly) and executes
    task automatic run_op(bit [15:0] opc, bit [15:0] keys);
        t_in_word w;
        bit [11:0] base;
        base = sb.idx;
        if (opc[15:12] == 4'hD) begin
            for (int r = 0; r < opc[3:0]; r++) fill_byte(base + 12'(r));
        end else if (opc[15:12] == 4'hF && opc[7:0] == 8'h65) begin
            for (int i = 0; i <= opc[11:8]; i++) fill_byte(base + 12'(i));
        end
        if (!sb.known[sb.pc] || !sb.known[sb.pc + 12'd1] || $urandom_range(0, 9) != 0) begin
            write_byte(sb.pc, opc[15:8]);
            write_byte(sb.pc + 12'd1, opc[7:0]);
        end
        w = rand_word(OP_EXEC);
        w.key_state = keys;
        send_word(w);
    endtask

    function automatic bit [15:0] gen_opcode();
        bit [3:0]  x;
        bit [3:0]  y;
        bit [7:0]  nn;
        bit [7:0]  alu_n [10] = '{0, 1, 2, 3, 4, 5, 6, 7, 8'hE, 8'h9};
        bit [7:0]  f_nn [12] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29,
                                 8'h33, 8'h55, 8'h65, 8'h18, 8'h15, 8'h00};
        x = $urandom_range(0, 15);
        y = $urandom_range(0, 15);
        nn = $urandom;
        case ($urandom_range(0, 23))
            0: return 16'h00E0;
            1: return 16'h00EE;
            2: return {4'h1, 12'($urandom)};
            3: return {4'h2, 12'($urandom)};
            4: return {4'h3, x, $urandom_range(0, 1) ? sb.vreg[x] : nn};
            5: return {4'h4, x, $urandom_range(0, 1) ? sb.vreg[x] : nn};
            6: return {4'h5, x, y, 4'($urandom)};
            7, 8: return {4'h6, x, nn};
            9: return {4'h7, x, nn};
            10, 11, 12: return {4'h8, x, y, alu_n[$urandom_range(0, 9)][3:0]};
            13: return {4'h9, x, y, 4'($urandom)};
            14: return {4'hA, 12'($urandom)};
            15: return {4'hB, 12'($urandom)};
            16: return {4'hC, x, nn};
            17, 18: return {4'hD, x, y, 4'($urandom)};
            19: return {4'hE, x, $urandom_range(0, 1) ? 8'h9E : 8'hA1};
            20, 21, 22: return {4'hF, x, f_nn[$urandom_range(0, 11)]};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic rand_step();
        t_in_word w;
        case ($urandom_range(0, 9))
            0: send_word(rand_word(OP_WRITE));
            1: send_word(rand_word(OP_READ_ROW));
            2: send_word(rand_word(OP_NOP));
            default: run_op(gen_opcode(), 16'($urandom));
        endcase
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_start(bit [11:0] a);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= a;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_start(a);
    endtask

    // receiver side stalls, with one long hold so the core backs up
    initial begin
        int cyc;
        cyc = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 6000) begin
                i_out_stall <= 1'b1;
                repeat (500) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat (gap_len() + 1) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    initial begin
        #20ms;
        $display("chip8_cpu_core_unit_tb failed");
        $finish;
    end

    initial begin
        bit [15:0] dir_ops [] = '{
            16'h00E0, 16'h600F, 16'hF029, 16'hD015, 16'hD015, 16'h611E, 16'hD01F,
            16'h6FFF, 16'h8FF4, 16'h62FF, 16'h6301, 16'h8234, 16'h8235, 16'h8237,
            16'h8236, 16'h823E, 16'h8238, 16'h0123, 16'hF0FF, 16'hE1FF, 16'hF20A,
            16'h6290, 16'hF233, 16'hF255, 16'hF165, 16'h6010, 16'hE09E, 16'hE0A1,
            16'h6005, 16'hE09E, 16'hE0A1, 16'hD000, 16'hB123, 16'hAFFE, 16'hD012,
            16'h00EE
        };
        bit [11:0] starts [4];
        t_in_word w;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        tx_quiet = 0;
        rx_quiet = 0;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (100) @(posedge i_clk);

        // directed part at the reset start address
        foreach (dir_ops[i]) run_op(dir_ops[i], i[0] ? 16'hFFFF : 16'h0020);
        w = rand_word(OP_READ_ROW); w.row_select = 5'd0; send_word(w);
        w = rand_word(OP_READ_ROW); w.row_select = 5'd31; send_word(w);
        write_byte(12'hFFF, 8'hFF);
        // overfill the stack, then unwind past empty
        repeat (STACK_SLOTS + 1) run_op({4'h2, 12'($urandom)}, 16'($urandom));
        repeat (STACK_SLOTS + 2) run_op(16'h00EE, 16'($urandom));
        repeat (150) rand_step();

        starts = '{12'h000, 12'hFFF, 12'($urandom), 12'h200};
        foreach (starts[p]) begin
            i_in_valid <= 1'b0;
            wait_idle();
            write_start(starts[p]);
            tx_quiet = (p == 1);
            rx_quiet = (p == 1);
            repeat (150) rand_step();
        end

        i_in_valid <= 1'b0;
        wait_idle();
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("chip8_cpu_core_unit_tb passed");
        end else begin
            $display("chip8_cpu_core_unit_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
